/* design/lrsp_pkg.sv */
// ---------------------------------------------------------------------------
// lrsp_pkg
// Shared types and codes for the LR shift-reduce parser engine.
// ---------------------------------------------------------------------------
package lrsp_pkg;

   localparam int RED_W = 6;

   typedef enum logic [1:0] {
      ACT_WR_CELL = 2'd0,
      ACT_WR_PROD = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_TOKEN   = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      KIND_ERROR  = 2'd0,
      KIND_SHIFT  = 2'd1,
      KIND_REDUCE = 2'd2,
      KIND_ACCEPT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_LOAD   = 3'd0,
      EV_SHIFT  = 3'd1,
      EV_REDUCE = 3'd2,
      EV_ACCEPT = 3'd3,
      EV_ERROR  = 3'd4
   } ev_type;

   typedef enum logic [1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_EMPTY = 2'd1,
      CAUSE_STACK = 2'd2,
      CAUSE_LIMIT = 2'd3
   } cause_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_CELL,
      ST_PROD,
      ST_GOTO_RD,
      ST_GOTO
   } ctrl_state_type;

   typedef enum logic [1:0] {
      STK_HOLD,
      STK_PUSH,
      STK_SET,
      STK_RESTART
   } stk_op_type;

   typedef struct packed {
      stk_op_type op;
      logic [5:0] value;
   } stk_cmd_type;

   typedef struct packed {
      logic [5:0] top;
      logic       full;
      logic       underflow;
   } stk_stat_type;

   typedef struct packed {
      logic       en;
      logic [5:0] row;
      logic [4:0] col;
      logic [7:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic      valid;
      ev_type    ev;
      logic [4:0] prod;
      cause_type cause;
      logic      last;
   } rsp_type;

endpackage

/* design/lr_shift_reduce_parser.sv */
// ---------------------------------------------------------------------------
// lr_shift_reduce_parser
// Table-driven LR shift-reduce parser engine.
//
// Items enter on start when busy is low; req_action selects table write,
// production write, restart or token. Results leave on rsp_* with rsp_valid
// high for exactly one cycle each; the receiver cannot stall them.
// Load and restart items: one result in the next cycle, busy stays low, so
// loads may follow back to back.
// Token items: busy rises unless halted; the first table read (LOOK, then
// CELL) gives a shift, accept or error result, registered as busy falls,
// and the next item can be taken while that result is shown. A reduction
// adds a production read, stack read, goto read, update and table read,
// bounded by the shared table port. rsp_last marks the final result.
// After reset a clearing sweep writes every table cell to error, one cell
// per cycle, 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) cells, 2048 at the
// default sizes; busy is high meanwhile. The stack then holds state 0.
// ---------------------------------------------------------------------------
module lr_shift_reduce_parser
   import lrsp_pkg::*;
#(
   parameter int NUM_STATES      = 64,
   parameter int NUM_SYMBOLS     = 32,
   parameter int NUM_PRODUCTIONS = 32,
   parameter int STACK_DEPTH     = 64,
   parameter int MAX_REDUCE      = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [5:0] req_row_state,
   input  logic [4:0] req_column_symbol,
   input  logic [1:0] req_entry_kind,
   input  logic [5:0] req_entry_value,
   input  logic [4:0] req_prod_number,
   input  logic [4:0] req_prod_head,
   input  logic [3:0] req_prod_length,
   input  logic [4:0] req_token_symbol,
   output logic       rsp_valid,
   output logic [2:0] rsp_event_res,
   output logic [5:0] rsp_new_state,
   output logic [4:0] rsp_production,
   output logic [1:0] rsp_error_cause,
   output logic [6:0] rsp_stack_depth,
   output logic       rsp_last
);

   localparam int DW = $clog2(STACK_DEPTH + 1);

   tbl_wr_type    tbl_wr;
   logic [5:0]    tbl_rd_state;
   logic [4:0]    tbl_rd_symbol;
   logic [7:0]    tbl_cell;
   logic          tbl_clearing;
   stk_cmd_type   stk_cmd;
   logic [3:0]    stk_len;
   stk_stat_type  stk_stat;
   logic [5:0]    stk_rd;
   logic [DW-1:0] stk_depth;
   logic [DW+6:0] depth_x;

   lrsp_table #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_state  (tbl_rd_state),
      .rd_symbol (tbl_rd_symbol),
      .rd_cell   (tbl_cell),
      .clearing  (tbl_clearing)
   );

   lrsp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stk_cmd),
      .len     (stk_len),
      .stat    (stk_stat),
      .rd_data (stk_rd),
      .depth   (stk_depth)
   );

   lrsp_ctrl #(
      .NUM_PRODUCTIONS (NUM_PRODUCTIONS),
      .MAX_REDUCE      (MAX_REDUCE)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_row_state     (req_row_state),
      .req_column_symbol (req_column_symbol),
      .req_entry_kind    (req_entry_kind),
      .req_entry_value   (req_entry_value),
      .req_prod_number   (req_prod_number),
      .req_prod_head     (req_prod_head),
      .req_prod_length   (req_prod_length),
      .req_token_symbol  (req_token_symbol),
      .tbl_clearing      (tbl_clearing),
      .tbl_wr            (tbl_wr),
      .tbl_rd_state      (tbl_rd_state),
      .tbl_rd_symbol     (tbl_rd_symbol),
      .tbl_cell          (tbl_cell),
      .stk_cmd           (stk_cmd),
      .stk_len           (stk_len),
      .stk_stat          (stk_stat),
      .stk_rd            (stk_rd),
      .rsp_valid         (rsp_valid),
      .rsp_event_res     (rsp_event_res),
      .rsp_production    (rsp_production),
      .rsp_error_cause   (rsp_error_cause),
      .rsp_last          (rsp_last)
   );

   assign depth_x         = {7'b0, stk_depth};
   assign rsp_stack_depth = depth_x[6:0];
   assign rsp_new_state   = stk_stat.top;

endmodule

/* design/lrsp_table.sv */
// ---------------------------------------------------------------------------
// lrsp_table
// Parse table memory with registered lookup and a clearing sweep after reset.
// ---------------------------------------------------------------------------
module lrsp_table
   import lrsp_pkg::*;
#(
   parameter int NUM_STATES  = 64,
   parameter int NUM_SYMBOLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  tbl_wr_type wr,
   input  logic [5:0] rd_state,
   input  logic [4:0] rd_symbol,
   output logic [7:0] rd_cell,
   output logic       clearing
);

   localparam int SW    = $clog2(NUM_STATES);
   localparam int YW    = $clog2(NUM_SYMBOLS);
   localparam int TW    = SW + YW;
   localparam int DEPTH = 1 << TW;

   logic [7:0]       mem [0:DEPTH-1];
   logic [7:0]       rd_ff;
   logic             ok_ff;
   logic             clearing_ff, clearing_in;
   logic [TW-1:0]    clr_ff, clr_in;

   logic [SW+5:0]    wr_st_x, rd_st_x;
   logic [YW+4:0]    wr_sy_x, rd_sy_x;
   logic [TW-1:0]    waddr, raddr, mem_waddr;
   logic             wr_ok, rd_ok, mem_we;
   logic [7:0]       mem_wdata;

   always_comb begin
      wr_st_x = {{SW{1'b0}}, wr.row};
      wr_sy_x = {{YW{1'b0}}, wr.col};
      rd_st_x = {{SW{1'b0}}, rd_state};
      rd_sy_x = {{YW{1'b0}}, rd_symbol};
      waddr   = {wr_st_x[SW-1:0], wr_sy_x[YW-1:0]};
      raddr   = {rd_st_x[SW-1:0], rd_sy_x[YW-1:0]};
      wr_ok   = (int'(wr.row) < NUM_STATES) && (int'(wr.col) < NUM_SYMBOLS);
      rd_ok   = (int'(rd_state) < NUM_STATES) && (int'(rd_symbol) < NUM_SYMBOLS);
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr.en && wr_ok;
         mem_waddr = waddr;
         mem_wdata = wr.data;
      end
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (&clr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[raddr];
      ok_ff <= rd_ok;
   end

   assign rd_cell  = ok_ff ? rd_ff : '0;
   assign clearing = clearing_ff;

endmodule

/* design/lrsp_stack.sv */
// ---------------------------------------------------------------------------
// lrsp_stack
// State stack memory with top-of-stack and depth registers.
// ---------------------------------------------------------------------------
module lrsp_stack
   import lrsp_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  stk_cmd_type   cmd,
   input  logic [3:0]    len,
   output stk_stat_type  stat,
   output logic [5:0]    rd_data,
   output logic [$clog2(STACK_DEPTH+1)-1:0] depth
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = (DW > 4) ? DW : 4;

   logic [5:0]    mem [0:STACK_DEPTH-1];
   logic [5:0]    top_ff, top_in;
   logic [DW-1:0] sp_ff, sp_in;
   logic [5:0]    rd_ff;

   logic [EW-1:0] sp_e, len_e, base_e, base_m1, base_p1;
   logic          wr_en;
   logic [AW-1:0] wr_idx;
   logic [5:0]    wr_data;

   always_comb begin
      sp_e    = EW'(sp_ff);
      len_e   = EW'(len);
      base_e  = sp_e - len_e;
      base_m1 = base_e - EW'(1);
      base_p1 = base_e + EW'(1);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = sp_ff[AW-1:0];
      wr_data = cmd.value;
      top_in  = top_ff;
      sp_in   = sp_ff;
      unique case (cmd.op)
         STK_HOLD: begin
         end
         STK_PUSH: begin
            wr_en  = 1'b1;
            top_in = cmd.value;
            sp_in  = sp_ff + 1'b1;
         end
         STK_SET: begin
            wr_en  = 1'b1;
            wr_idx = base_e[AW-1:0];
            top_in = cmd.value;
            sp_in  = base_p1[DW-1:0];
         end
         STK_RESTART: begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            wr_data = '0;
            top_in  = '0;
            sp_in   = DW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         sp_ff  <= DW'(1);
      end else begin
         top_ff <= top_in;
         sp_ff  <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_ff <= mem[base_m1[AW-1:0]];
   end

   assign stat.top       = top_ff;
   assign stat.full      = sp_ff >= DW'(STACK_DEPTH);
   assign stat.underflow = (len_e >= sp_e) || (base_e >= EW'(STACK_DEPTH));
   assign rd_data        = rd_ff;
   assign depth          = sp_ff;

endmodule

/* design/lrsp_ctrl.sv */
// ---------------------------------------------------------------------------
// lrsp_ctrl
// Parse sequencer: item decode, production store, reduction loop, results.
// ---------------------------------------------------------------------------
module lrsp_ctrl
   import lrsp_pkg::*;
#(
   parameter int NUM_PRODUCTIONS = 32,
   parameter int MAX_REDUCE      = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_action,
   input  logic [5:0]   req_row_state,
   input  logic [4:0]   req_column_symbol,
   input  logic [1:0]   req_entry_kind,
   input  logic [5:0]   req_entry_value,
   input  logic [4:0]   req_prod_number,
   input  logic [4:0]   req_prod_head,
   input  logic [3:0]   req_prod_length,
   input  logic [4:0]   req_token_symbol,
   input  logic         tbl_clearing,
   output tbl_wr_type   tbl_wr,
   output logic [5:0]   tbl_rd_state,
   output logic [4:0]   tbl_rd_symbol,
   input  logic [7:0]   tbl_cell,
   output stk_cmd_type  stk_cmd,
   output logic [3:0]   stk_len,
   input  stk_stat_type stk_stat,
   input  logic [5:0]   stk_rd,
   output logic         rsp_valid,
   output logic [2:0]   rsp_event_res,
   output logic [4:0]   rsp_production,
   output logic [1:0]   rsp_error_cause,
   output logic         rsp_last
);

   localparam int PW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;

   ctrl_state_type   state_ff, state_in;
   rsp_type          rsp_ff, rsp_in;
   logic             halted_ff, halted_in;
   logic [4:0]       tok_ff, tok_in;
   logic [4:0]       prod_ff, prod_in;
   logic [RED_W-1:0] red_ff, red_in;

   logic [8:0]       pmem [0:NUM_PRODUCTIONS-1];
   logic [8:0]       prod_rd_ff;
   logic             prod_we, prod_re;
   logic [PW+4:0]    pw_x;
   logic [PW+5:0]    pr_x;

   logic [1:0]       cell_kind;
   logic [5:0]       cell_val;
   logic             act_start;

   assign cell_kind = tbl_cell[7:6];
   assign cell_val  = tbl_cell[5:0];
   assign busy      = state_ff != ST_IDLE;
   assign act_start = start && !busy;
   assign pw_x      = {{PW{1'b0}}, req_prod_number};
   assign pr_x      = {{PW{1'b0}}, cell_val};
   assign stk_len   = prod_rd_ff[3:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!tbl_clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (act_start && req_action == ACT_TOKEN && !halted_ff) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CELL;
         end
         ST_CELL: begin
            if (cell_kind == KIND_REDUCE && int'(cell_val) < NUM_PRODUCTIONS
                && red_ff < RED_W'(MAX_REDUCE)) begin
               state_in = ST_PROD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PROD: begin
            state_in = stk_stat.underflow ? ST_IDLE : ST_GOTO_RD;
         end
         ST_GOTO_RD: begin
            state_in = ST_GOTO;
         end
         ST_GOTO: begin
            state_in = (cell_kind == KIND_SHIFT) ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      rsp_in        = '{valid: 1'b0, ev: EV_LOAD, prod: '0, cause: CAUSE_NONE, last: 1'b1};
      halted_in     = halted_ff;
      tok_in        = tok_ff;
      prod_in       = prod_ff;
      red_in        = red_ff;
      prod_we       = 1'b0;
      prod_re       = 1'b0;
      tbl_wr.en     = 1'b0;
      tbl_wr.row    = req_row_state;
      tbl_wr.col    = req_column_symbol;
      tbl_wr.data   = {req_entry_kind, req_entry_value};
      tbl_rd_state  = stk_stat.top;
      tbl_rd_symbol = tok_ff;
      stk_cmd       = '{op: STK_HOLD, value: cell_val};
      unique case (state_ff)
         ST_CLEAR: begin
            stk_cmd.op = STK_RESTART;
         end
         ST_IDLE: begin
            if (act_start) begin
               rsp_in.valid = 1'b1;
               unique case (req_action)
                  ACT_WR_CELL: begin
                     tbl_wr.en = 1'b1;
                  end
                  ACT_WR_PROD: begin
                     prod_we = int'(req_prod_number) < NUM_PRODUCTIONS;
                  end
                  ACT_RESTART: begin
                     stk_cmd.op = STK_RESTART;
                     halted_in  = 1'b0;
                  end
                  default: begin
                     if (halted_ff) begin
                        rsp_in.ev    = EV_ERROR;
                        rsp_in.cause = CAUSE_LIMIT;
                     end else begin
                        rsp_in.valid = 1'b0;
                        tok_in       = req_token_symbol;
                        red_in       = '0;
                     end
                  end
               endcase
            end
         end
         ST_LOOK: begin
         end
         ST_CELL: begin
            rsp_in.valid = 1'b1;
            halted_in    = 1'b1;
            rsp_in.ev    = EV_ERROR;
            rsp_in.cause = CAUSE_EMPTY;
            if (cell_kind == KIND_ACCEPT) begin
               rsp_in.ev    = EV_ACCEPT;
               rsp_in.cause = CAUSE_NONE;
            end else if (cell_kind == KIND_SHIFT) begin
               if (stk_stat.full) begin
                  rsp_in.cause = CAUSE_STACK;
               end else begin
                  halted_in    = 1'b0;
                  stk_cmd.op   = STK_PUSH;
                  rsp_in.ev    = EV_SHIFT;
                  rsp_in.cause = CAUSE_NONE;
               end
            end else if (cell_kind == KIND_REDUCE && int'(cell_val) < NUM_PRODUCTIONS) begin
               if (red_ff >= RED_W'(MAX_REDUCE)) begin
                  rsp_in.cause = CAUSE_LIMIT;
               end else begin
                  rsp_in.valid = 1'b0;
                  halted_in    = 1'b0;
                  prod_re      = 1'b1;
                  prod_in      = cell_val[4:0];
               end
            end
         end
         ST_PROD: begin
            if (stk_stat.underflow) begin
               rsp_in.valid = 1'b1;
               rsp_in.ev    = EV_ERROR;
               rsp_in.cause = CAUSE_STACK;
               halted_in    = 1'b1;
            end
         end
         ST_GOTO_RD: begin
            tbl_rd_state  = stk_rd;
            tbl_rd_symbol = prod_rd_ff[8:4];
         end
         ST_GOTO: begin
            rsp_in.valid = 1'b1;
            if (cell_kind == KIND_SHIFT) begin
               stk_cmd.op  = STK_SET;
               red_in      = red_ff + 1'b1;
               rsp_in.ev   = EV_REDUCE;
               rsp_in.prod = prod_ff;
               rsp_in.last = 1'b0;
            end else begin
               rsp_in.ev    = EV_ERROR;
               rsp_in.cause = CAUSE_EMPTY;
               halted_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rsp_ff    <= '0;
         halted_ff <= 1'b0;
         red_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_ff    <= rsp_in;
         halted_ff <= halted_in;
         red_ff    <= red_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (prod_we) begin
         pmem[pw_x[PW-1:0]] <= {req_prod_head, req_prod_length};
      end
      if (prod_re) begin
         prod_rd_ff <= pmem[pr_x[PW-1:0]];
      end
   end

   assign rsp_valid       = rsp_ff.valid;
   assign rsp_event_res   = rsp_ff.ev;
   assign rsp_production  = rsp_ff.prod;
   assign rsp_error_cause = rsp_ff.cause;
   assign rsp_last        = rsp_ff.last;

`ifndef SYNTH
   a_halt_on_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && (rsp_ff.ev == EV_ERROR || rsp_ff.ev == EV_ACCEPT)) |-> halted_ff)
      else $error("accept or error result without halt");

   a_reduce_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.ev == EV_REDUCE) |-> (state_ff == ST_LOOK && !rsp_ff.last))
      else $error("reduce result not followed by a new lookup");

   a_goto_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GOTO) |-> ($past(state_ff) == ST_GOTO_RD))
      else $error("goto decision without goto read");

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_ff.valid)
      else $error("result during table clear");
`endif

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LR shift-reduce parser engine.
// Named tests load grammars into the parse table and production store, then
// run token streams through them. A built-in predictor tracks the table, the
// rules, the state stack and the halt flag, and queues the results each item
// should cause. A checker compares every strobed result, field by field, with
// the oldest queued one. The directed tests cover a small expression grammar,
// every error cause, a full stack and the reduction limit. Random sessions
// follow, with random grammars and token streams and varying sender gaps.
// ----------------------------------------------------------------------------
module tb
   import lrsp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ST    = 64;
   localparam int NUM_SYM   = 32;
   localparam int NUM_RULES = 32;
   localparam int STK_MAX   = 64;
   localparam int RED_MAX   = 63;
   localparam int EXP_SLOTS = 1024;

   typedef struct {
      act_type    action;
      logic [5:0] row;
      logic [4:0] col;
      kind_type   kind;
      logic [5:0] value;
      logic [4:0] pnum;
      logic [4:0] phead;
      logic [3:0] plen;
      logic [4:0] tok;
   } parse_item_type;

   typedef struct {
      ev_type     ev;
      logic [5:0] top;
      logic [4:0] prod;
      cause_type  cause;
      logic [6:0] depth;
      logic       last;
   } parse_result_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_action;
   logic [5:0] req_row_state;
   logic [4:0] req_column_symbol;
   logic [1:0] req_entry_kind;
   logic [5:0] req_entry_value;
   logic [4:0] req_prod_number;
   logic [4:0] req_prod_head;
   logic [3:0] req_prod_length;
   logic [4:0] req_token_symbol;
   logic       rsp_valid;
   logic [2:0] rsp_event_res;
   logic [5:0] rsp_new_state;
   logic [4:0] rsp_production;
   logic [1:0] rsp_error_cause;
   logic [6:0] rsp_stack_depth;
   logic       rsp_last;

   kind_type   tbl_kind [NUM_ST][NUM_SYM];
   logic [5:0] tbl_val [NUM_ST][NUM_SYM];
   logic [4:0] rule_head [NUM_RULES];
   logic [3:0] rule_len [NUM_RULES];
   logic [5:0] stk [STK_MAX];
   int         depth;
   bit         parse_halted;

   parse_result_type expected_results [EXP_SLOTS];
   int exp_head;
   int exp_tail;
   int idle_pct;
   int items_sent;
   int tokens_sent;
   int results_checked;
   int mismatches;
   int event_tally [5];

   lr_shift_reduce_parser dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_row_state     (req_row_state),
      .req_column_symbol (req_column_symbol),
      .req_entry_kind    (req_entry_kind),
      .req_entry_value   (req_entry_value),
      .req_prod_number   (req_prod_number),
      .req_prod_head     (req_prod_head),
      .req_prod_length   (req_prod_length),
      .req_token_symbol  (req_token_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_event_res     (rsp_event_res),
      .rsp_new_state     (rsp_new_state),
      .rsp_production    (rsp_production),
      .rsp_error_cause   (rsp_error_cause),
      .rsp_stack_depth   (rsp_stack_depth),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic void queue_result(ev_type ev, logic [4:0] prod, cause_type cause,
                                        logic last);
      parse_result_type r;
      r.ev    = ev;
      r.top   = stk[depth - 1];
      r.prod  = prod;
      r.cause = cause;
      r.depth = 7'(depth);
      r.last  = last;
      expected_results[exp_tail % EXP_SLOTS] = r;
      exp_tail++;
   endfunction

   function automatic void queue_error(cause_type cause);
      parse_halted = 1'b1;
      queue_result(EV_ERROR, 5'd0, cause, 1'b1);
   endfunction

   // advance the parser state for one item and queue what it should report
   function automatic void parse_item_model(parse_item_type it);
      int         reductions;
      bit         done;
      kind_type   ck;
      logic [5:0] cv;
      logic [5:0] below;
      logic [4:0] head;
      int         len;
      int         base;
      case (it.action)
         ACT_WR_CELL: begin
            tbl_kind[it.row][it.col] = it.kind;
            tbl_val[it.row][it.col]  = it.value;
            queue_result(EV_LOAD, 5'd0, CAUSE_NONE, 1'b1);
         end
         ACT_WR_PROD: begin
            rule_head[it.pnum] = it.phead;
            rule_len[it.pnum]  = it.plen;
            queue_result(EV_LOAD, 5'd0, CAUSE_NONE, 1'b1);
         end
         ACT_RESTART: begin
            stk[0]       = 6'd0;
            depth        = 1;
            parse_halted = 1'b0;
            queue_result(EV_LOAD, 5'd0, CAUSE_NONE, 1'b1);
         end
         default: begin
            if (parse_halted) begin
               queue_result(EV_ERROR, 5'd0, CAUSE_LIMIT, 1'b1);
            end else begin
               reductions = 0;
               done = 1'b0;
               while (!done) begin
                  ck = tbl_kind[stk[depth - 1]][it.tok];
                  cv = tbl_val[stk[depth - 1]][it.tok];
                  done = 1'b1;
                  if (ck == KIND_ACCEPT) begin
                     parse_halted = 1'b1;
                     queue_result(EV_ACCEPT, 5'd0, CAUSE_NONE, 1'b1);
                  end else if (ck == KIND_SHIFT) begin
                     if (depth >= STK_MAX) begin
                        queue_error(CAUSE_STACK);
                     end else begin
                        stk[depth] = cv;
                        depth++;
                        queue_result(EV_SHIFT, 5'd0, CAUSE_NONE, 1'b1);
                     end
                  end else if (ck == KIND_REDUCE && cv < NUM_RULES) begin
                     head = rule_head[cv[4:0]];
                     len  = rule_len[cv[4:0]];
                     base = depth - len;
                     if (reductions >= RED_MAX) begin
                        queue_error(CAUSE_LIMIT);
                     end else if (len >= depth || base >= STK_MAX) begin
                        queue_error(CAUSE_STACK);
                     end else begin
                        below = stk[base - 1];
                        if (tbl_kind[below][head] != KIND_SHIFT) begin
                           queue_error(CAUSE_EMPTY);
                        end else begin
                           stk[base] = tbl_val[below][head];
                           depth = base + 1;
                           reductions++;
                           queue_result(EV_REDUCE, cv[4:0], CAUSE_NONE, 1'b0);
                           done = 1'b0;
                        end
                     end
                  end else begin
                     queue_error(CAUSE_EMPTY);
                  end
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (exp_tail == exp_head) begin
            report_mismatch($sformatf("unexpected result, event %0d", rsp_event_res));
         end else begin
            want = expected_results[exp_head % EXP_SLOTS];
            exp_head++;
            if (rsp_event_res !== want.ev)
               report_mismatch($sformatf("event_res got %0d want %0d",
                                         rsp_event_res, want.ev));
            if (rsp_new_state !== want.top)
               report_mismatch($sformatf("new_state got %0d want %0d",
                                         rsp_new_state, want.top));
            if (rsp_production !== want.prod)
               report_mismatch($sformatf("production got %0d want %0d",
                                         rsp_production, want.prod));
            if (rsp_error_cause !== want.cause)
               report_mismatch($sformatf("error_cause got %0d want %0d",
                                         rsp_error_cause, want.cause));
            if (rsp_stack_depth !== want.depth)
               report_mismatch($sformatf("stack_depth got %0d want %0d",
                                         rsp_stack_depth, want.depth));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %0d want %0d", rsp_last, want.last));
            results_checked++;
            event_tally[int'(want.ev)]++;
         end
      end
   end

   function automatic parse_item_type noise_item();
      parse_item_type it;
      it.action = act_type'($urandom_range(3));
      it.row    = 6'($urandom_range(63));
      it.col    = 5'($urandom_range(31));
      it.kind   = kind_type'($urandom_range(3));
      it.value  = 6'($urandom_range(63));
      it.pnum   = 5'($urandom_range(31));
      it.phead  = 5'($urandom_range(31));
      it.plen   = 4'($urandom_range(15));
      it.tok    = 5'($urandom_range(31));
      return it;
   endfunction

   // hold start high from one item to the next; drop it only on a gap
   task automatic send_item(input parse_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_action        = it.action;
      req_row_state     = it.row;
      req_column_symbol = it.col;
      req_entry_kind    = it.kind;
      req_entry_value   = it.value;
      req_prod_number   = it.pnum;
      req_prod_head     = it.phead;
      req_prod_length   = it.plen;
      req_token_symbol  = it.tok;
      start             = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      parse_item_model(it);
      items_sent++;
      if (it.action == ACT_TOKEN)
         tokens_sent++;
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      start = 1'b0;
      while (exp_tail != exp_head) @(posedge clock);
   endtask

   task automatic put_cell(input logic [5:0] row, input logic [4:0] col,
                           input kind_type kind, input logic [5:0] value);
      parse_item_type it;
      it        = noise_item();
      it.action = ACT_WR_CELL;
      it.row    = row;
      it.col    = col;
      it.kind   = kind;
      it.value  = value;
      send_item(it);
   endtask

   task automatic put_prod(input logic [4:0] num, input logic [4:0] head,
                           input logic [3:0] len);
      parse_item_type it;
      it        = noise_item();
      it.action = ACT_WR_PROD;
      it.pnum   = num;
      it.phead  = head;
      it.plen   = len;
      send_item(it);
   endtask

   task automatic restart_parse();
      parse_item_type it;
      it        = noise_item();
      it.action = ACT_RESTART;
      send_item(it);
   endtask

   task automatic feed_token(input logic [4:0] tok);
      parse_item_type it;
      it        = noise_item();
      it.action = ACT_TOKEN;
      it.tok    = tok;
      send_item(it);
   endtask

   function automatic logic [5:0] pick_state();
      return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
   endfunction

   function automatic logic [4:0] pick_token();
      return ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
   endfunction

   function automatic logic [4:0] pick_head();
      return ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'(16 + $urandom_range(3));
   endfunction

   // every rule gets written so no reduction ever reads an unwritten one
   task automatic test_load_productions();
      idle_pct = 0;
      put_prod(5'd0, 5'd0, 4'd0);
      for (int p = 1; p < NUM_RULES - 1; p++)
         put_prod(5'(p), 5'($urandom_range(31)), 4'($urandom_range(15)));
      put_prod(5'd31, 5'd31, 4'd15);
      wait_results_done();
   endtask

   task automatic test_cleared_table();
      idle_pct = 0;
      restart_parse();
      feed_token(5'd0);
      feed_token(5'd31);
      restart_parse();
      wait_results_done();
   endtask

   // E -> E + n | n, with '+' on symbol 31 and E on symbol 10
   task automatic test_expression_parse();
      int expr_toks [6] = '{1, 31, 1, 31, 1, 0};
      idle_pct = 0;
      put_prod(5'd2, 5'd10, 4'd1);
      put_prod(5'd31, 5'd10, 4'd3);
      put_cell(6'd0, 5'd1, KIND_SHIFT, 6'd2);
      put_cell(6'd0, 5'd10, KIND_SHIFT, 6'd1);
      put_cell(6'd1, 5'd31, KIND_SHIFT, 6'd63);
      put_cell(6'd1, 5'd0, KIND_ACCEPT, 6'd0);
      put_cell(6'd2, 5'd0, KIND_REDUCE, 6'd2);
      put_cell(6'd2, 5'd31, KIND_REDUCE, 6'd2);
      put_cell(6'd63, 5'd1, KIND_SHIFT, 6'd4);
      put_cell(6'd4, 5'd0, KIND_REDUCE, 6'd31);
      put_cell(6'd4, 5'd31, KIND_REDUCE, 6'd31);
      restart_parse();
      foreach (expr_toks[i])
         feed_token(5'(expr_toks[i]));
      feed_token(5'd1);
      restart_parse();
      feed_token(5'd1);
      feed_token(5'd5);
      wait_results_done();
   endtask

   task automatic test_reduce_errors();
      idle_pct = 53;
      put_prod(5'd5, 5'd20, 4'd1);
      put_prod(5'd6, 5'd25, 4'd0);
      put_cell(6'd0, 5'd20, KIND_REDUCE, 6'd32);
      put_cell(6'd0, 5'd21, KIND_REDUCE, 6'd5);
      put_cell(6'd0, 5'd22, KIND_REDUCE, 6'd6);
      put_cell(6'd0, 5'd25, KIND_ACCEPT, 6'd63);
      restart_parse();
      feed_token(5'd20);
      restart_parse();
      feed_token(5'd21);
      restart_parse();
      feed_token(5'd22);
      wait_results_done();
   endtask

   task automatic test_stack_overflow();
      idle_pct = 0;
      put_prod(5'd7, 5'd27, 4'd0);
      put_cell(6'd0, 5'd23, KIND_SHIFT, 6'd12);
      put_cell(6'd12, 5'd23, KIND_REDUCE, 6'd7);
      put_cell(6'd12, 5'd27, KIND_SHIFT, 6'd12);
      put_cell(6'd12, 5'd24, KIND_SHIFT, 6'd12);
      restart_parse();
      feed_token(5'd23);
      feed_token(5'd23);
      restart_parse();
      feed_token(5'd23);
      repeat (STK_MAX - 1) feed_token(5'd24);
      feed_token(5'd24);
      wait_results_done();
   endtask

   task automatic test_reduce_limit();
      idle_pct = 7;
      put_prod(5'd8, 5'd28, 4'd1);
      put_cell(6'd0, 5'd26, KIND_SHIFT, 6'd5);
      put_cell(6'd5, 5'd26, KIND_REDUCE, 6'd8);
      put_cell(6'd0, 5'd28, KIND_SHIFT, 6'd5);
      put_cell(6'd0, 5'd29, KIND_REDUCE, 6'd7);
      put_cell(6'd0, 5'd27, KIND_SHIFT, 6'd0);
      restart_parse();
      feed_token(5'd26);
      feed_token(5'd26);
      restart_parse();
      feed_token(5'd29);
      wait_results_done();
   endtask

   task automatic test_random_sessions(input int pct, input int num_items);
      int         stop_at;
      logic [5:0] row;
      logic [4:0] col;
      kind_type   kind;
      logic [5:0] value;
      idle_pct = pct;
      stop_at = items_sent + num_items;
      while (items_sent < stop_at) begin
         repeat ($urandom_range(2))
            put_prod(5'($urandom_range(31)), pick_head(),
                     ($urandom_range(5) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(2)));
         repeat ($urandom_range(2, 6)) begin
            row   = pick_state();
            col   = pick_token();
            kind  = KIND_SHIFT;
            value = pick_state();
            case ($urandom_range(9))
               0, 1, 2: col = pick_head();
               3, 4, 5: ;
               6, 7: begin
                  kind  = KIND_REDUCE;
                  value = ($urandom_range(9) == 0) ? 6'(32 + $urandom_range(31))
                                                   : 6'($urandom_range(31));
               end
               8: kind = KIND_ACCEPT;
               default: begin
                  kind  = KIND_ERROR;
                  col   = 5'($urandom_range(31));
                  value = 6'($urandom_range(63));
               end
            endcase
            put_cell(row, col, kind, value);
         end
         restart_parse();
         repeat ($urandom_range(2, 10)) begin
            case ($urandom_range(19))
               0: restart_parse();
               1: send_item(noise_item());
               default: feed_token(pick_token());
            endcase
            if (parse_halted && $urandom_range(3) != 0)
               break;
         end
      end
      wait_results_done();
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = '0;
      req_row_state     = '0;
      req_column_symbol = '0;
      req_entry_kind    = '0;
      req_entry_value   = '0;
      req_prod_number   = '0;
      req_prod_head     = '0;
      req_prod_length   = '0;
      req_token_symbol  = '0;
      exp_head          = 0;
      exp_tail          = 0;
      idle_pct          = 0;
      items_sent        = 0;
      tokens_sent       = 0;
      results_checked   = 0;
      mismatches        = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
      foreach (tbl_kind[s, c]) begin
         tbl_kind[s][c] = KIND_ERROR;
         tbl_val[s][c]  = 6'd0;
      end
      foreach (rule_head[p]) begin
         rule_head[p] = 5'd0;
         rule_len[p]  = 4'd0;
      end
      foreach (stk[i]) stk[i] = 6'd0;
      depth        = 1;
      parse_halted = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_productions();
      test_cleared_table();
      test_expression_parse();
      test_reduce_errors();
      test_stack_overflow();
      test_reduce_limit();
      test_random_sessions(0, 50);
      test_random_sessions(53, 50);
      test_random_sessions(7, 50);

      wait_results_done();
      repeat (24) @(posedge clock);
      $display("Sent %0d items (%0d tokens); checked %0d results, %0d mismatches.",
               items_sent, tokens_sent, results_checked, mismatches);
      $display("Seen: %0d loads, %0d shifts, %0d reductions, %0d accepts, %0d errors.",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3],
               event_tally[4]);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
